/* rtl/hdwt_pkg.sv */
// Shared constants and types for the one-level 2D Haar transform core.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps

package hdwt_pkg;

	localparam int COORD_BITS     = 11;
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 11;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTION  = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_WIDTH = 4'd1;

	localparam logic [COORD_BITS-1:0] HALF_WIDTH_RESET = 11'd256;

	localparam logic [1:0] QUAD_FIRST = 2'd0;
	localparam logic [1:0] QUAD_LAST  = 2'd3;

	typedef enum logic {
		DIR_FORWARD = 1'b0,
		DIR_INVERSE = 1'b1
	} dir_mode_t;

	// Block coordinates as handed from the front end to the emitter.
	typedef struct packed {
		dir_mode_t             mode;
		logic [COORD_BITS-1:0] row_base;
		logic [COORD_BITS-1:0] col_base;
	} blk_ctl_t;

endpackage

/* rtl/hdwt_if.sv */
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on hdwt_pkg for coordinate and register port widths.
`timescale 1ns / 1ps

interface hdwt_in_if #(parameter int SAMPLE_BITS = 18);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic                          frame_start;

	modport source (output valid, output sample_value, output frame_start, input ready);
	modport sink   (input valid, input sample_value, input frame_start, output ready);
endinterface

interface hdwt_out_if #(parameter int SAMPLE_BITS = 18);
	logic                                 valid;
	logic                                 ready;
	logic signed [SAMPLE_BITS:0]          result_value;
	logic [1:0]                           quadrant;
	logic [hdwt_pkg::COORD_BITS-1:0]      out_row;
	logic [hdwt_pkg::COORD_BITS-1:0]      out_col;
	logic                                 block_last;

	modport source (output valid, output result_value, output quadrant, output out_row,
		output out_col, output block_last, input ready);
	modport sink   (input valid, input result_value, input quadrant, input out_row,
		input out_col, input block_last, output ready);
endinterface

interface hdwt_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [hdwt_pkg::CFG_INDEX_BITS-1:0] index;
	logic [hdwt_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/hdwt_front.sv */
// Front end: raster counters, line memory and the stage that gathers a 2x2 block.
// Depends on hdwt_pkg and hdwt_in_if.
`timescale 1ns / 1ps

module hdwt_front #(
	parameter int MAX_LINE    = 2048,
	parameter int SAMPLE_BITS = 18
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	hdwt_in_if.sink                               samples,
	input  hdwt_pkg::dir_mode_t                   mode,
	input  logic [hdwt_pkg::COORD_BITS-1:0]       half_width,
	output logic                                  blk_valid,
	input  logic                                  blk_ready,
	output logic signed [SAMPLE_BITS-1:0]         blk_a,
	output logic signed [SAMPLE_BITS-1:0]         blk_b,
	output logic signed [SAMPLE_BITS-1:0]         blk_c,
	output logic signed [SAMPLE_BITS-1:0]         blk_d,
	output hdwt_pkg::blk_ctl_t                    blk_ctl
);
	import hdwt_pkg::*;

	localparam int CW  = $clog2(MAX_LINE);
	localparam int HCW = (CW + 1 > COORD_BITS) ? CW + 1 : COORD_BITS;
	localparam int XW  = (CW > COORD_BITS) ? CW : COORD_BITS;
	localparam logic [HCW-1:0] HALF_MAX = HCW'(MAX_LINE / 2);

	logic [CW-1:0]         col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [CW-1:0]         col_cur;
	logic [COORD_BITS-1:0] row_cur;
	logic [CW:0]           col_nxt;
	logic [HCW-1:0]        hw_ext;
	logic [HCW-1:0]        hw_sat;
	logic [HCW:0]          row_len;
	logic                  row_wrap;
	logic                  accept;
	logic                  in_ready;

	logic [SAMPLE_BITS-1:0] line_mem [MAX_LINE];
	logic signed [SAMPLE_BITS-1:0] rdata_q;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [CW-1:0]                 col_s1;
	logic [COORD_BITS-1:0]         row_s1;
	logic                          s1_blk;
	logic                          s1_drain;

	logic signed [SAMPLE_BITS-1:0] a_q;
	logic signed [SAMPLE_BITS-1:0] c_q;

	logic [XW-1:0] col_x;

	assign accept  = samples.valid && in_ready;
	assign col_cur = samples.frame_start ? '0 : col_q;
	assign row_cur = samples.frame_start ? '0 : row_q;

	assign hw_ext   = HCW'(half_width);
	assign hw_sat   = (hw_ext == '0) ? HCW'(1) : ((hw_ext > HALF_MAX) ? HALF_MAX : hw_ext);
	assign row_len  = {hw_sat, 1'b0};
	assign col_nxt  = {1'b0, col_cur} + (CW + 1)'(1);
	assign row_wrap = (HCW + 1)'(col_nxt) >= row_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_wrap) begin
				col_q <= '0;
				row_q <= row_cur + COORD_BITS'(1);
			end else begin
				col_q <= col_nxt[CW-1:0];
				row_q <= row_cur;
			end
		end
	end

	// Even rows fill the line, odd rows read it back one entry per beat.
	always_ff @(posedge clk) begin
		if (accept && !row_cur[0]) begin
			line_mem[col_cur] <= samples.sample_value;
		end
		if (accept && row_cur[0]) begin
			rdata_q <= line_mem[col_cur];
		end
	end

	assign s1_blk   = row_s1[0] && col_s1[0];
	assign s1_drain = valid_s1 && (!s1_blk || blk_ready);
	assign in_ready = !valid_s1 || s1_drain;
	assign samples.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= samples.sample_value;
			col_s1    <= col_cur;
			row_s1    <= row_cur;
		end
	end

	// Hold upper-left and lower-left of the pair from the even-column beat.
	always_ff @(posedge clk) begin
		if (s1_drain && row_s1[0] && !col_s1[0]) begin
			a_q <= rdata_q;
			c_q <= sample_s1;
		end
	end

	assign col_x = XW'(col_s1);

	always_comb begin
		blk_ctl.mode = mode;
		if (mode == DIR_FORWARD) begin
			blk_ctl.row_base = row_s1 >> 1;
			blk_ctl.col_base = COORD_BITS'(col_x >> 1);
		end else begin
			blk_ctl.row_base = row_s1 - COORD_BITS'(1);
			blk_ctl.col_base = COORD_BITS'(col_x - XW'(1));
		end
	end

	assign blk_valid = valid_s1 && s1_blk;
	assign blk_a     = a_q;
	assign blk_b     = rdata_q;
	assign blk_c     = c_q;
	assign blk_d     = sample_s1;

endmodule

/* rtl/hdwt_emit.sv */
// Emitter: forms the four half sums of a block and sends them as four result beats.
// Depends on hdwt_pkg and hdwt_out_if.
`timescale 1ns / 1ps

module hdwt_emit #(
	parameter int SAMPLE_BITS = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          blk_valid,
	output logic                          blk_ready,
	input  logic signed [SAMPLE_BITS-1:0] blk_a,
	input  logic signed [SAMPLE_BITS-1:0] blk_b,
	input  logic signed [SAMPLE_BITS-1:0] blk_c,
	input  logic signed [SAMPLE_BITS-1:0] blk_d,
	input  hdwt_pkg::blk_ctl_t            blk_ctl,
	hdwt_out_if.source                    results
);
	import hdwt_pkg::*;

	localparam int SW = SAMPLE_BITS + 2;

	logic                   busy_q;
	logic [1:0]             idx_q;
	logic [SAMPLE_BITS:0]   vals_q [4];
	blk_ctl_t               ctl_q;
	logic                   load;
	logic                   beat_done;
	logic                   on_last;

	logic signed [SW-1:0] ea, eb, ec, ed;
	logic signed [SW-1:0] s_ll, s_lh, s_hl, s_hh;

	assign on_last   = idx_q == QUAD_LAST;
	assign beat_done = busy_q && results.ready;
	assign blk_ready = !busy_q || (on_last && results.ready);
	assign load      = blk_valid && blk_ready;

	assign ea = SW'(blk_a);
	assign eb = SW'(blk_b);
	assign ec = SW'(blk_c);
	assign ed = SW'(blk_d);

	assign s_ll = ea + eb + ec + ed;
	assign s_lh = ea + eb - ec - ed;
	assign s_hl = ea - eb + ec - ed;
	assign s_hh = ea - eb - ec + ed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= QUAD_FIRST;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= QUAD_FIRST;
		end else if (beat_done) begin
			if (on_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_q     <= blk_ctl;
			vals_q[0] <= s_ll[SW-1:1];
			vals_q[3] <= s_hh[SW-1:1];
			if (blk_ctl.mode == DIR_FORWARD) begin
				vals_q[1] <= s_lh[SW-1:1];
				vals_q[2] <= s_hl[SW-1:1];
			end else begin
				vals_q[1] <= s_hl[SW-1:1];
				vals_q[2] <= s_lh[SW-1:1];
			end
		end
	end

	assign results.valid        = busy_q;
	assign results.result_value = vals_q[idx_q];
	assign results.quadrant     = idx_q;
	assign results.block_last   = on_last;
	assign results.out_row      = ctl_q.row_base
		+ COORD_BITS'((ctl_q.mode == DIR_INVERSE) && idx_q[1]);
	assign results.out_col      = ctl_q.col_base
		+ COORD_BITS'((ctl_q.mode == DIR_INVERSE) && idx_q[0]);

	a_load_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && busy_q) |-> (on_last && results.ready))
		else $error("block loaded over a block still being sent");

	a_idx_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_done && !on_last) |=> (busy_q && idx_q == 2'($past(idx_q) + 2'd1)))
		else $error("beat index did not advance");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_done && on_last && !load) |=> !busy_q)
		else $error("emitter stayed busy after the last beat");

endmodule

/* rtl/haar_dwt_2d_one_level_core.sv */
// Top level of the one-level 2D Haar transform: register file, front end, emitter.
// Depends on hdwt_pkg, hdwt_if, hdwt_front and hdwt_emit.
//
// channel   dir  beat
// cfg       in   index, data (direction_mode, half_width)
// samples   in   sample_value, frame_start
// results   out  result_value, quadrant, out_row, out_col, block_last
//
// Even rows take one sample per cycle into the line memory while samples.ready is high.
// An odd row takes a column pair. Its block leaves as four result beats, one per cycle
// while results.ready is high; the single emitter takes a new block only on the last beat.
// The odd-column sample is registered in the gathering stage, then in the emitter.
// Reset clears counters and sets forward mode and half width 256; line memory is not cleared.
// A stalled result holds the emitter and the gathering stage and drops samples.ready.
`timescale 1ns / 1ps

module haar_dwt_2d_one_level_core #(
	parameter int MAX_LINE    = 2048,
	parameter int SAMPLE_BITS = 18
) (
	input  logic         clk,
	input  logic         arst_n,
	hdwt_cfg_if.sink     cfg,
	hdwt_in_if.sink      samples,
	hdwt_out_if.source   results
);
	import hdwt_pkg::*;

	dir_mode_t             mode_q;
	logic [COORD_BITS-1:0] half_width_q;

	logic                          blk_valid;
	logic                          blk_ready;
	logic signed [SAMPLE_BITS-1:0] blk_a;
	logic signed [SAMPLE_BITS-1:0] blk_b;
	logic signed [SAMPLE_BITS-1:0] blk_c;
	logic signed [SAMPLE_BITS-1:0] blk_d;
	blk_ctl_t                      blk_ctl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= DIR_FORWARD;
			half_width_q <= HALF_WIDTH_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_DIRECTION) begin
				mode_q <= dir_mode_t'(cfg.data[0]);
			end else if (cfg.index == CFG_HALF_WIDTH) begin
				half_width_q <= cfg.data[COORD_BITS-1:0];
			end
		end
	end

	hdwt_front #(
		.MAX_LINE    (MAX_LINE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.mode       (mode_q),
		.half_width (half_width_q),
		.blk_valid  (blk_valid),
		.blk_ready  (blk_ready),
		.blk_a      (blk_a),
		.blk_b      (blk_b),
		.blk_c      (blk_c),
		.blk_d      (blk_d),
		.blk_ctl    (blk_ctl)
	);

	hdwt_emit #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.blk_a     (blk_a),
		.blk_b     (blk_b),
		.blk_c     (blk_c),
		.blk_d     (blk_d),
		.blk_ctl   (blk_ctl),
		.results   (results)
	);

endmodule
